// File: rtl/los_pkg.sv
// Shared constants and types for the Langevin oscillator step block.
package los_pkg;

  localparam int WORD_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF  = 32;

  localparam int CFG_W     = 47;
  localparam int ROOT_W    = 33;
  localparam int CFG_IDX_W = 2;

  localparam logic [ROOT_W-1:0] ROOT_RESET = 33'h1_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_SPRING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd3;

  typedef struct packed {
    logic start;
    logic half;
  } mul_req_t;

endpackage

// File: rtl/los_mul.sv
// Shared multi-cycle signed multiplier with rounding and saturation to the word.
module los_mul #(
  parameter int WORD_WIDTH = los_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = los_pkg::FRAC_BITS_DEF,
  parameter int OP_WIDTH   = los_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  los_pkg::mul_req_t            req,
  input  logic signed [OP_WIDTH-1:0]   op_a,
  input  logic signed [OP_WIDTH-1:0]   op_b,
  output logic signed [WORD_WIDTH-1:0] result,
  output logic                         done
);

  localparam int HALF  = (OP_WIDTH + 1) / 2;
  localparam int ACC_W = 4 * HALF;
  localparam int PW    = ACC_W + 2;

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_PROD  = 2'd1;
  localparam logic [1:0] M_SIGN  = 2'd2;
  localparam logic [1:0] M_ROUND = 2'd3;

  localparam logic signed [PW-1:0] ONE_P  = PW'(1);
  localparam logic signed [PW-1:0] RND_F  = ONE_P <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RND_H  = ONE_P <<< FRAC_BITS;
  localparam logic signed [PW-1:0] WMAX_P = (ONE_P <<< (WORD_WIDTH - 1)) - ONE_P;
  localparam logic signed [PW-1:0] WMIN_P = -WMAX_P - ONE_P;

  logic [1:0]           phase;
  logic [2:0]           cnt;
  logic [2*HALF-1:0]    ma;
  logic [2*HALF-1:0]    mb;
  logic                 neg;
  logic                 half_q;
  logic [2*HALF-1:0]    pp;
  logic [1:0]           pp_shift;
  logic [ACC_W-1:0]     acc;
  logic signed [PW-1:0] prod;

  logic [OP_WIDTH-1:0]  mag_a;
  logic [OP_WIDTH-1:0]  mag_b;
  logic [HALF-1:0]      a_sel;
  logic [HALF-1:0]      b_sel;
  logic [2*HALF-1:0]    pp_full;
  logic [ACC_W-1:0]     pp_ext;
  logic [ACC_W-1:0]     pp_aligned;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] quo;
  logic signed [WORD_WIDTH-1:0] sat;

  assign mag_a = op_a[OP_WIDTH-1] ? (~op_a + {{(OP_WIDTH-1){1'b0}}, 1'b1}) : op_a;
  assign mag_b = op_b[OP_WIDTH-1] ? (~op_b + {{(OP_WIDTH-1){1'b0}}, 1'b1}) : op_b;

  assign a_sel   = cnt[0] ? ma[2*HALF-1:HALF] : ma[HALF-1:0];
  assign b_sel   = cnt[1] ? mb[2*HALF-1:HALF] : mb[HALF-1:0];
  assign pp_full = (2*HALF)'(a_sel) * (2*HALF)'(b_sel);

  assign pp_ext = ACC_W'(pp);

  always_comb begin
    case (pp_shift)
      2'd0:    pp_aligned = pp_ext;
      2'd1:    pp_aligned = pp_ext << HALF;
      default: pp_aligned = pp_ext << (2 * HALF);
    endcase
  end

  always_comb begin
    rnd = prod + (half_q ? RND_H : RND_F);
    quo = half_q ? (rnd >>> (FRAC_BITS + 1)) : (rnd >>> FRAC_BITS);
    if (quo > WMAX_P) begin
      sat = WMAX_P[WORD_WIDTH-1:0];
    end else if (quo < WMIN_P) begin
      sat = WMIN_P[WORD_WIDTH-1:0];
    end else begin
      sat = quo[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
      done  <= 1'b0;
      cnt   <= 3'd0;
    end else begin
      done <= (phase == M_ROUND);
      case (phase)
        M_IDLE: begin
          if (req.start) begin
            phase <= M_PROD;
            cnt   <= 3'd0;
          end
        end
        M_PROD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            phase <= M_SIGN;
          end
        end
        M_SIGN: begin
          phase <= M_ROUND;
        end
        default: begin
          phase <= M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == M_IDLE && req.start) begin
      ma     <= (2*HALF)'(mag_a);
      mb     <= (2*HALF)'(mag_b);
      neg    <= op_a[OP_WIDTH-1] ^ op_b[OP_WIDTH-1];
      half_q <= req.half;
      acc    <= '0;
    end
    if (phase == M_PROD) begin
      pp       <= pp_full;
      pp_shift <= 2'(cnt[0]) + 2'(cnt[1]);
      if (cnt != 3'd0) begin
        acc <= acc + pp_aligned;
      end
    end
    if (phase == M_SIGN) begin
      prod <= neg ? -$signed({2'b00, acc}) : $signed({2'b00, acc});
    end
    if (phase == M_ROUND) begin
      result <= sat;
    end
  end

endmodule

// File: rtl/langevin_oscillator_step_top.sv
// Top level: one Langevin step of a noisy damped oscillator per input beat.
// Each beat runs nine multiplies in sequence on one shared multiplier, each made of
// four partial products, sign, rounding and handoff; a new beat is taken only once
// the previous one has been emitted.
// A finished result waits in its own output register while the next beat is taken.
// Reset (synchronous, active high) clears position, velocity, the sequencer and
// sets the registers to their reset values (damping root one, others zero).
module langevin_oscillator_step_top #(
  parameter int WORD_WIDTH = los_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = los_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [los_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [los_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // noise_first, noise_second (from bit 0 up), zero fill to whole bytes
  input  logic [((2*WORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // position, velocity (from bit 0 up), zero fill to whole bytes
  output logic [((2*WORD_WIDTH+7)/8)*8-1:0] m_tdata
);

  localparam int W    = WORD_WIDTH;
  localparam int TD_W = ((2*WORD_WIDTH+7)/8)*8;
  localparam int OPW  = (WORD_WIDTH > los_pkg::CFG_W) ? WORD_WIDTH : los_pkg::CFG_W + 1;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [3:0] ST_FORCE_A = 4'd0;
  localparam logic [3:0] ST_KICK_A  = 4'd1;
  localparam logic [3:0] ST_DAMP_A  = 4'd2;
  localparam logic [3:0] ST_NOISE_A = 4'd3;
  localparam logic [3:0] ST_DRIFT   = 4'd4;
  localparam logic [3:0] ST_FORCE_B = 4'd5;
  localparam logic [3:0] ST_KICK_B  = 4'd6;
  localparam logic [3:0] ST_DAMP_B  = 4'd7;
  localparam logic [3:0] ST_NOISE_B = 4'd8;

  logic [los_pkg::CFG_W-1:0]  spring_coef;
  logic [los_pkg::CFG_W-1:0]  time_step;
  logic [los_pkg::ROOT_W-1:0] damping_root;
  logic [los_pkg::CFG_W-1:0]  noise_gain;

  logic [1:0]          state;
  logic [3:0]          step;
  logic signed [W-1:0] position_store;
  logic signed [W-1:0] velocity_store;
  logic signed [W-1:0] half_vel;
  logic signed [W-1:0] tmp;
  logic signed [W-1:0] noise_first;
  logic signed [W-1:0] noise_second;
  logic signed [W-1:0] pos_out;
  logic signed [W-1:0] vel_out;
  logic                out_valid;

  los_pkg::mul_req_t     mul_req;
  logic signed [OPW-1:0] mul_a;
  logic signed [OPW-1:0] mul_b;
  logic signed [W-1:0]   mul_res;
  logic                  mul_done;

  logic signed [OPW-1:0] k_op;
  logic signed [OPW-1:0] dt_op;
  logic signed [OPW-1:0] r_op;
  logic signed [OPW-1:0] g_op;
  logic signed [W-1:0]   neg_tmp;
  logic signed [W-1:0]   add_a;
  logic signed [W-1:0]   add_sum;
  logic                  emit_fire;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = (W+1)'(a) + (W+1)'(b);
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? WMIN : WMAX;
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] a);
    if (a == WMIN) begin
      sat_neg = WMAX;
    end else begin
      sat_neg = -a;
    end
  endfunction

  assign k_op    = $signed(OPW'(spring_coef));
  assign dt_op   = $signed(OPW'(time_step));
  assign r_op    = $signed(OPW'(damping_root));
  assign g_op    = $signed(OPW'(noise_gain));
  assign neg_tmp = sat_neg(tmp);

  always_comb begin
    mul_req.start = (state == S_ISSUE);
    mul_req.half  = 1'b0;
    mul_a         = k_op;
    mul_b         = OPW'(position_store);
    add_a         = half_vel;
    case (step)
      ST_FORCE_A, ST_FORCE_B: begin
        mul_a = k_op;
        mul_b = OPW'(position_store);
      end
      ST_KICK_A, ST_KICK_B: begin
        mul_a        = OPW'(neg_tmp);
        mul_b        = dt_op;
        mul_req.half = 1'b1;
      end
      ST_DAMP_A: begin
        mul_a = r_op;
        mul_b = OPW'(velocity_store);
        add_a = tmp;
      end
      ST_NOISE_A: begin
        mul_a = g_op;
        mul_b = OPW'(noise_first);
      end
      ST_DRIFT: begin
        mul_a = OPW'(half_vel);
        mul_b = dt_op;
        add_a = position_store;
      end
      ST_DAMP_B: begin
        mul_a = r_op;
        mul_b = OPW'(half_vel);
      end
      ST_NOISE_B: begin
        mul_a = g_op;
        mul_b = OPW'(noise_second);
        add_a = tmp;
      end
      default: begin
        mul_a = k_op;
        mul_b = OPW'(position_store);
      end
    endcase
  end

  assign add_sum = sat_add(add_a, mul_res);

  los_mul #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .OP_WIDTH  (OPW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .req   (mul_req),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .result(mul_res),
    .done  (mul_done)
  );

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = TD_W'({vel_out, pos_out});
  assign emit_fire = (state == S_EMIT) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_coef  <= '0;
      time_step    <= '0;
      damping_root <= los_pkg::ROOT_RESET;
      noise_gain   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        los_pkg::REG_SPRING: spring_coef  <= cfg_data;
        los_pkg::REG_DT:     time_step    <= cfg_data;
        los_pkg::REG_ROOT:   damping_root <= cfg_data[los_pkg::ROOT_W-1:0];
        los_pkg::REG_GAIN:   noise_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= ST_FORCE_A;
      position_store <= '0;
      velocity_store <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && m_tready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            step  <= ST_FORCE_A;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            case (step)
              ST_DRIFT:   position_store <= add_sum;
              ST_NOISE_B: velocity_store <= add_sum;
              default: ;
            endcase
            if (step == ST_NOISE_B) begin
              state <= S_EMIT;
            end else begin
              step  <= step + 4'd1;
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          if (emit_fire) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      noise_first  <= s_tdata[W-1:0];
      noise_second <= s_tdata[2*W-1:W];
    end
    if (state == S_WAIT && mul_done) begin
      case (step)
        ST_FORCE_A, ST_KICK_A, ST_FORCE_B, ST_DAMP_B: tmp <= mul_res;
        ST_DAMP_A, ST_NOISE_A, ST_KICK_B:             half_vel <= add_sum;
        default: ;
      endcase
    end
    if (emit_fire) begin
      pos_out <= position_store;
      vel_out <= velocity_store;
    end
  end

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_WAIT)
    else $error("multiplier finished outside the wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_ISSUE && step == ST_FORCE_A))
    else $error("accepted beat did not start the sequence");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (out_valid && state == S_IDLE))
    else $error("finished step did not reach the output register");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |-> step <= ST_NOISE_B)
    else $error("sequencer step out of range");
`endif

endmodule
